// ===== rtl/clock_snapshot_time_translator_core_assert.svh =====
// Assertion macros for the clock snapshot time translator.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef CLOCK_SNAPSHOT_TIME_TRANSLATOR_CORE_ASSERT_SVH
`define CLOCK_SNAPSHOT_TIME_TRANSLATOR_CORE_ASSERT_SVH

// Checked only outside reset.
`define CSTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CSTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/cstt_pkg.sv =====
// Shared types and constants for the clock snapshot time translator.
// No dependencies.
package cstt_pkg;

  localparam int unsigned DOMAINS_DEF = 8;
  localparam int unsigned DEPTH_DEF   = 256;
  localparam int unsigned TIME_W      = 64;

  typedef enum logic {
    MODE_PUSH    = 1'b0,
    MODE_CONVERT = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_P_CMP_CLK,
    S_P_CMP_TRC,
    S_P_WR,
    S_C_PROBE,
    S_C_CMP,
    S_C_SUB,
    S_C_ADD,
    S_DONE
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    mode_e                    mode;
    logic [2:0]               domain;
    logic signed [TIME_W-1:0] clock_time;
    logic signed [TIME_W-1:0] trace_time;
  } in_req_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] trace_time_out;
    status_e                  status;
  } out_rsp_t;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_ctl_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              lt;   // signed a < b, valid for ALU_SUB
  } alu_res_t;

endpackage

// ===== rtl/cstt_alu.sv =====
// Shared 64-bit add / subtract unit with signed less-than flag.
// Depends on cstt_pkg.
module cstt_alu import cstt_pkg::*; (
  input  alu_ctl_t ctl_i,
  output alu_res_t res_o
);

  logic [TIME_W:0] a_x;
  logic [TIME_W:0] b_x;
  logic [TIME_W:0] sum_x;

  // Sign-extend one bit so the top bit of a - b is the signed compare.
  assign a_x   = {ctl_i.a[TIME_W-1], ctl_i.a};
  assign b_x   = (ctl_i.op == ALU_SUB) ? ~{ctl_i.b[TIME_W-1], ctl_i.b}
                                       : {ctl_i.b[TIME_W-1], ctl_i.b};
  assign sum_x = a_x + b_x + {{TIME_W{1'b0}}, (ctl_i.op == ALU_SUB)};

  assign res_o.sum = sum_x[TIME_W-1:0];
  assign res_o.lt  = sum_x[TIME_W];

endmodule

// ===== rtl/clock_snapshot_time_translator_core.sv =====
// Clock snapshot time translator: per-domain snapshot lists with binary-search convert.
// Depends on cstt_pkg, cstt_alu and clock_snapshot_time_translator_core_assert.svh.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o with an in_req_t payload; each
//   request yields exactly one response on out_valid_o/out_ready_i.
//   A push request appends a (clock, trace) pair to its domain's list; the
//   response carries status only. A convert request searches the domain's
//   list and returns the translated trace time.
//   One request is processed at a time; in_ready_o is high only when idle.
//   A push checks the new clock and then the trace time against the list's
//   last pair and writes only if neither is lower (an empty list skips the
//   check; a full list drops the push). A convert takes k <= ceil(log2(n+1))
//   search steps for a list of n pairs, each one snapshot-memory read and
//   one pass through the shared 64-bit adder; an empty domain skips the search.
//   The result sits in an output register, so a stalled receiver holds one
//   response while the next request is accepted and worked on; the block
//   then waits in its final state until the output register frees up.
//   Reset empties every domain at once (per-domain valid bits); the snapshot
//   memories need no clearing pass.
`include "clock_snapshot_time_translator_core_assert.svh"

module clock_snapshot_time_translator_core import cstt_pkg::*; #(
  parameter int unsigned DOMAINS = DOMAINS_DEF,
  parameter int unsigned DEPTH   = DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_data_o
);

  localparam int unsigned ENTRIES = DOMAINS * DEPTH;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned DIW     = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam int unsigned DXW     = (DIW > 3) ? DIW : 3;
  localparam logic [AW-1:0] BaseStep = AW'(DEPTH);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [6:0]    DomLim   = 7'(DOMAINS);

  function automatic logic [DIW-1:0] dom_index(input logic [2:0] d);
    logic [DXW-1:0] x;
    x = DXW'(d);
    return x[DIW-1:0];
  endfunction

  state_e state_q, state_d;
  in_req_t req_q, req_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic lt_q, lt_d;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic [TIME_W-1:0] res_q, res_d;
  status_e stat_q, stat_d;
  out_rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [DOMAINS-1:0] cnt_valid_q, cnt_valid_d;

  // Snapshot and count memories
  logic [TIME_W-1:0] clk_mem [ENTRIES];
  logic [TIME_W-1:0] trc_mem [ENTRIES];
  logic [CW-1:0]     cnt_mem [DOMAINS];
  logic [TIME_W-1:0] rd_clk_q;
  logic [TIME_W-1:0] rd_trc_q;
  logic [CW-1:0]     cnt_rd_q;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          cnt_re;
  logic          cnt_we;

  alu_ctl_t alu_ctl;
  alu_res_t alu_res;

  logic            in_fire;
  logic            out_free;
  logic            dom_ok;
  logic [DIW-1:0]  dom_idx;
  logic [DIW-1:0]  in_dom_idx;
  logic [CW-1:0]   n_cur;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;
  logic [CW-1:0]   last_idx;
  logic [CW-1:0]   n_prev;
  logic            search_on;

  cstt_alu u_alu (
    .ctl_i (alu_ctl),
    .res_o (alu_res)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_dom_idx = dom_index(in_data_i.domain);
  assign dom_idx    = dom_index(req_q.domain);
  assign dom_ok     = (7'(req_q.domain) < DomLim);
  assign n_cur      = (dom_ok && cnt_valid_q[dom_idx]) ? cnt_rd_q : '0;
  assign n_prev     = n_cur - CW'(1);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[CW:1];
  assign last_idx   = (lo_q == '0) ? '0 : (lo_q - CW'(1));
  assign search_on  = (lo_q < hi_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (req_q.mode == MODE_PUSH) begin
          priority if (!dom_ok || n_cur == DepthC) state_d = S_DONE;
          else if (n_cur == '0)                    state_d = S_P_WR;
          else                                     state_d = S_P_CMP_CLK;
        end else begin
          if (!dom_ok || n_cur == '0) state_d = S_DONE;
          else                        state_d = S_C_PROBE;
        end
      end
      S_P_CMP_CLK: state_d = S_P_CMP_TRC;
      S_P_CMP_TRC: state_d = (lt_q || alu_res.lt) ? S_DONE : S_P_WR;
      S_P_WR:      state_d = S_DONE;
      S_C_PROBE:   state_d = search_on ? S_C_CMP : S_C_SUB;
      S_C_CMP:     state_d = S_C_PROBE;
      S_C_SUB:     state_d = S_C_ADD;
      S_C_ADD:     state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    req_d       = req_q;
    base_d      = base_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lt_d        = lt_q;
    diff_d      = diff_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_valid_d = cnt_valid_q;
    mem_re      = 1'b0;
    mem_raddr   = base_q;
    mem_we      = 1'b0;
    mem_waddr   = base_q + AW'(n_q[IW-1:0]);
    cnt_re      = 1'b0;
    cnt_we      = 1'b0;
    alu_ctl.op  = ALU_SUB;
    alu_ctl.a   = req_q.clock_time;
    alu_ctl.b   = rd_clk_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d  = in_data_i;
          base_d = AW'(in_dom_idx) * BaseStep;
          cnt_re = 1'b1;
        end
      end
      S_LOAD: begin
        n_d  = n_cur;
        lo_d = '0;
        hi_d = n_cur;
        res_d  = '0;
        stat_d = ST_OK;
        if (req_q.mode == MODE_PUSH) begin
          priority if (!dom_ok || n_cur == DepthC) begin
            stat_d = ST_FULL;
          end else if (n_cur != '0) begin
            // fetch the last pair for the order check
            mem_re    = 1'b1;
            mem_raddr = base_q + AW'(n_prev[IW-1:0]);
          end
        end else begin
          if (!dom_ok || n_cur == '0) begin
            res_d  = req_q.clock_time;
            stat_d = ST_EMPTY;
          end
        end
      end
      S_P_CMP_CLK: begin
        lt_d = alu_res.lt;
      end
      S_P_CMP_TRC: begin
        alu_ctl.a = req_q.trace_time;
        alu_ctl.b = rd_trc_q;
        if (lt_q || alu_res.lt) stat_d = ST_ORDER;
      end
      S_P_WR: begin
        mem_we = 1'b1;
        cnt_we = 1'b1;
        cnt_valid_d[dom_idx] = 1'b1;
      end
      S_C_PROBE: begin
        mem_re = 1'b1;
        if (search_on) mem_raddr = base_q + AW'(mid[IW-1:0]);
        else           mem_raddr = base_q + AW'(last_idx[IW-1:0]);
      end
      S_C_CMP: begin
        // lo ends on the first entry above the query
        if (alu_res.lt) hi_d = mid;
        else            lo_d = mid + CW'(1);
      end
      S_C_SUB: begin
        diff_d = alu_res.sum;
      end
      S_C_ADD: begin
        alu_ctl.op = ALU_ADD;
        alu_ctl.a  = rd_trc_q;
        alu_ctl.b  = diff_q;
        res_d      = alu_res.sum;
      end
      S_DONE: begin
        if (out_free) begin
          out_d.trace_time_out = res_q;
          out_d.status         = stat_q;
          out_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_valid_q <= cnt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    base_q <= base_d;
    n_q    <= n_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    lt_q   <= lt_d;
    diff_q <= diff_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      clk_mem[mem_waddr] <= req_q.clock_time;
      trc_mem[mem_waddr] <= req_q.trace_time;
    end
    if (mem_re) begin
      rd_clk_q <= clk_mem[mem_raddr];
      rd_trc_q <= trc_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[dom_idx] <= n_q + CW'(1);
    if (cnt_re) cnt_rd_q <= cnt_mem[in_dom_idx];
  end

  `CSTT_ASSERT_ALWAYS(a_wr_in_range, (state_q == S_P_WR) |-> (n_q < DepthC), "push writes past the end of a list")
  `CSTT_ASSERT(a_wr_push_only, mem_we |-> (req_q.mode == MODE_PUSH && dom_ok), "snapshot write outside a valid push")
  `CSTT_ASSERT(a_probe_bounds, (state_q == S_C_PROBE) |-> (lo_q <= hi_q && hi_q <= n_q), "search bounds left the list")
  `CSTT_ASSERT(a_cmp_nonempty, (state_q == S_C_CMP) |-> $past(search_on), "search step taken on an empty interval")
  `CSTT_ASSERT(a_done_loads, (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE), "finished request did not reach the output register")

endmodule
